// ===== hw/rtl/amsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsr_pkg: shared types and constants
// Field widths, the configuration bundle, the pixel word that travels
// from the front end to the back end, and register indexes.
// ----------------------------------------------------------------------------
package amsr_pkg;

	// Fixed widths of the stream fields.
	localparam int SCORE_W  = 16;
	localparam int COORD_W  = 10;
	localparam int SIDE_W   = 11;
	localparam int LEN_W    = 12;
	localparam int IMG_W    = 16;
	localparam int THR_W    = 15;
	localparam int PAD_W    = 10;
	localparam int OUT_W    = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Largest image side in pixels.
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(1024);

	// Depth of the queue between front and back end.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THRESHOLD = 2'd0,
		REG_SQUARE_PAD      = 2'd1,
		REG_IMAGE_WIDTH     = 2'd2,
		REG_IMAGE_HEIGHT    = 2'd3
	} reg_index_t;

	// Configuration as seen by the datapath, sides already limited.
	typedef struct packed {
		logic [THR_W-1:0]  score_threshold;
		logic [PAD_W-1:0]  square_pad;
		logic [SIDE_W-1:0] width_side;
		logic [SIDE_W-1:0] height_side;
		logic [SIDE_W-1:0] min_side;
	} cfg_t;

	// One classified pixel.
	typedef struct packed {
		logic               fg;
		logic               done;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [IMG_W-1:0]   img;
	} pix_t;

	// A zero side acts as one, an oversized side as the largest side.
	function automatic logic [SIDE_W-1:0] side_limit(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_MAX) begin
			r = SIDE_MAX;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/argmax_mask_square_roi_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argmax_mask_square_roi_unit: argmax mask and square box of a score map
// Per-pixel argmax over streamed channel scores, a foreground mask word per
// pixel and a padded square box around the foreground of each image.
//
// Channel   Direction  Word
// s_axis    in         tdata: class_score[15:0]; tlast: last_channel
// m_axis    out        tdata: mask_bit, image_number, left_x, top_y,
//                      right_x, bottom_y; tlast: box_valid
// cfg       in         cfg_index selects the register, cfg_data the value
//
// One score word is taken per cycle while the queue is not full; the argmax
// compare and counter update in the front end set that figure. A pixel word
// passes from the queue through the four box stages and then the output
// register to m_axis. Reset is asynchronous, active low, and clears the
// control, configuration and box state, but not the queue storage or stage
// payload; no clearing pass is needed. A stalled m_axis holds the back end,
// and the front end keeps taking words until the four-entry queue fills.
// ----------------------------------------------------------------------------
module argmax_mask_square_roi_unit #(
	parameter int MAX_CHANNELS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Score stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [amsr_pkg::SCORE_W-1:0]         s_axis_tdata,  // class_score[15:0]
	input  logic                                 s_axis_tlast,  // last_channel
	// Mask and box stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// mask_bit[0], image_number[16:1], left_x[26:17], top_y[36:27],
	// right_x[46:37], bottom_y[56:47], zeros[63:57]
	output logic [amsr_pkg::OUT_W-1:0]           m_axis_tdata,
	output logic                                 m_axis_tlast,  // box_valid
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [amsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import amsr_pkg::*;

	logic [THR_W-1:0]  score_threshold_q;
	logic [PAD_W-1:0]  square_pad_q;
	logic [SIDE_W-1:0] image_width_q;
	logic [SIDE_W-1:0] image_height_q;

	cfg_t cfg;
	logic push, pop, q_full, q_not_empty;
	pix_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_threshold_q <= '0;
			square_pad_q      <= '0;
			image_width_q     <= SIDE_MAX;
			image_height_q    <= SIDE_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_SCORE_THRESHOLD: score_threshold_q <= cfg_data[THR_W-1:0];
				REG_SQUARE_PAD:      square_pad_q      <= cfg_data[PAD_W-1:0];
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[SIDE_W-1:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Limited sides and the smaller of the two.
	always_comb begin
		cfg.score_threshold = score_threshold_q;
		cfg.square_pad      = square_pad_q;
		cfg.width_side      = side_limit(image_width_q);
		cfg.height_side     = side_limit(image_height_q);
		cfg.min_side        = (cfg.width_side < cfg.height_side) ? cfg.width_side
			: cfg.height_side;
	end

	amsr_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.class_score  ($signed(s_axis_tdata)),
		.last_channel (s_axis_tlast),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	amsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	amsr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast)
	);

endmodule

// ===== hw/rtl/amsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsr_front: per-pixel argmax and raster position
// Accepts one channel score per word, keeps the running argmax and, on the
// last channel, pushes a classified pixel word into the queue.
// ----------------------------------------------------------------------------
module amsr_front #(
	parameter int MAX_CHANNELS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  amsr_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [amsr_pkg::SCORE_W-1:0] class_score,
	input  logic                              last_channel,
	input  logic                              q_full,
	output logic                              push,
	output amsr_pkg::pix_t                    push_data
);
	import amsr_pkg::*;

	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(MAX_CHANNELS - 1);

	logic [CH_W-1:0]          ch_q;
	logic [CH_W-1:0]          best_class_q;
	logic signed [SCORE_W-1:0] best_score_q;
	logic [COORD_W-1:0]       col_q;
	logic [COORD_W-1:0]       row_q;
	logic [IMG_W-1:0]         img_q;

	logic                     accept;
	logic                     take;
	logic signed [SCORE_W-1:0] nb_score;
	logic [CH_W-1:0]          nb_class;
	logic                     fg;
	logic                     col_end;
	logic                     row_end;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Running argmax; the first channel always wins, ties go to the later one.
	assign take     = (ch_q == '0) || (class_score >= best_score_q);
	assign nb_score = take ? class_score : best_score_q;
	assign nb_class = take ? ch_q : best_class_q;

	// Foreground test on the winner of this pixel.
	assign fg = (nb_score >= $signed({1'b0, cfg.score_threshold})) && (nb_class != '0);

	// Raster position tests.
	assign col_end = {1'b0, col_q} >= (cfg.width_side - SIDE_W'(1));
	assign row_end = {1'b0, row_q} >= (cfg.height_side - SIDE_W'(1));

	assign push           = accept && last_channel;
	assign push_data.fg   = fg;
	assign push_data.done = col_end && row_end;
	assign push_data.col  = col_q;
	assign push_data.row  = row_q;
	assign push_data.img  = img_q;

	// Channel, argmax and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q         <= '0;
			best_class_q <= '0;
			best_score_q <= '0;
			col_q        <= '0;
			row_q        <= '0;
			img_q        <= '0;
		end else if (accept) begin
			best_score_q <= nb_score;
			best_class_q <= nb_class;
			if (!last_channel) begin
				if (ch_q < CH_LAST) begin
					ch_q <= ch_q + CH_W'(1);
				end
			end else begin
				ch_q <= '0;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						img_q <= img_q + IMG_W'(1);
					end else begin
						row_q <= row_q + COORD_W'(1);
					end
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/amsr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsr_queue: pixel word queue
// A short first-in first-out buffer that lets the front and back ends
// stall independently.
// ----------------------------------------------------------------------------
module amsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  amsr_pkg::pix_t push_data,
	input  logic           pop,
	output amsr_pkg::pix_t pop_data,
	output logic           full,
	output logic           not_empty
);
	import amsr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/amsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amsr_back: bounding box and square box pipeline
// Gathers the foreground box per image and, on the image's last pixel,
// squares, pads, centers and clamps it over four stages and an output
// register. The whole pipeline advances together.
// ----------------------------------------------------------------------------
module amsr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  amsr_pkg::cfg_t                cfg,
	input  logic                          q_not_empty,
	input  amsr_pkg::pix_t                q_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [amsr_pkg::OUT_W-1:0]    out_data,
	output logic                          out_last
);
	import amsr_pkg::*;

	logic advance;

	// Box state of the current image.
	logic               any_q;
	logic [COORD_W-1:0] min_c_q, max_c_q, min_r_q, max_r_q;
	logic [COORD_W-1:0] n_min_c, n_max_c, n_min_r, n_max_r;
	logic               n_any;

	// Stage registers.
	logic               v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic               fg_s1, fg_s2, fg_s3, fg_s4;
	logic               done_s1, done_s2, done_s3, done_s4;
	logic [IMG_W-1:0]   img_s1, img_s2, img_s3, img_s4;
	logic [COORD_W-1:0] x1_s1, x2_s1, y1_s1, y2_s1;
	logic [COORD_W-1:0] x1_s2, y1_s2, x1_s3, y1_s3, x1_s4, y1_s4;
	logic [SIDE_W-1:0]  rw_s2, rh_s2, rw_s3, rh_s3;
	logic [SIDE_W-1:0]  sq_s3, sq_s4;

	// Output register.
	logic               fg_q, done_q;
	logic [IMG_W-1:0]   img_q;
	logic [COORD_W-1:0] lx_q, ty_q, rx_q, by_q;

	// Combinational stage results.
	logic [SIDE_W-1:0]  rw_c, rh_c, mx_c, sq_c, dx_c, dy_c;
	logic [LEN_W-1:0]   padded_c;
	logic signed [LEN_W-1:0] xm_c, ym_c;
	logic [COORD_W-1:0] x1c_c, y1c_c;
	logic [LEN_W-1:0]   xsum_c, ysum_c;
	logic [COORD_W-1:0] lx_c, rx_c, ty_c, by_c;

	assign advance   = !v_out_q || out_ready;
	assign pop       = advance && q_not_empty;
	assign out_valid = v_out_q;
	assign out_last  = done_q;
	assign out_data  = {{(OUT_W - 1 - IMG_W - 4 * COORD_W){1'b0}},
		by_q, rx_q, ty_q, lx_q, img_q, fg_q};

	// Box update with the pixel now leaving the queue.
	always_comb begin
		n_min_c = min_c_q;
		n_max_c = max_c_q;
		n_min_r = min_r_q;
		n_max_r = max_r_q;
		n_any   = any_q || q_data.fg;
		if (q_data.fg) begin
			if (!any_q) begin
				n_min_c = q_data.col;
				n_max_c = q_data.col;
				n_min_r = q_data.row;
				n_max_r = q_data.row;
			end else begin
				if (q_data.col < min_c_q) n_min_c = q_data.col;
				if (q_data.col > max_c_q) n_max_c = q_data.col;
				if (q_data.row < min_r_q) n_min_r = q_data.row;
				if (q_data.row > max_r_q) n_max_r = q_data.row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			min_c_q <= '0;
			max_c_q <= '0;
			min_r_q <= '0;
			max_r_q <= '0;
		end else if (pop) begin
			if (q_data.done) begin
				any_q   <= 1'b0;
				min_c_q <= '0;
				max_c_q <= '0;
				min_r_q <= '0;
				max_r_q <= '0;
			end else begin
				any_q   <= n_any;
				min_c_q <= n_min_c;
				max_c_q <= n_max_c;
				min_r_q <= n_min_r;
				max_r_q <= n_max_r;
			end
		end
	end

	// Stage 2: box sides.
	assign rw_c = {1'b0, x2_s1} - {1'b0, x1_s1} + SIDE_W'(1);
	assign rh_c = {1'b0, y2_s1} - {1'b0, y1_s1} + SIDE_W'(1);

	// Stage 3: square side, padded and limited by the image sides.
	assign mx_c     = (rw_s2 > rh_s2) ? rw_s2 : rh_s2;
	assign padded_c = {1'b0, mx_c} + {1'b0, cfg.square_pad, 1'b0};
	assign sq_c     = (padded_c > {1'b0, cfg.min_side}) ? cfg.min_side
		: padded_c[SIDE_W-1:0];

	// Stage 4: center the near edges, clamped at zero.
	assign dx_c = sq_s3 - rw_s3;
	assign dy_c = sq_s3 - rh_s3;
	assign xm_c = $signed({2'b00, x1_s3}) - $signed({2'b00, dx_c[SIDE_W-1:1]});
	assign ym_c = $signed({2'b00, y1_s3}) - $signed({2'b00, dy_c[SIDE_W-1:1]});
	always_comb begin
		x1c_c = x1_s3;
		y1c_c = y1_s3;
		if (rw_s3 < sq_s3) begin
			x1c_c = xm_c[LEN_W-1] ? '0 : xm_c[COORD_W-1:0];
		end
		if (rh_s3 < sq_s3) begin
			y1c_c = ym_c[LEN_W-1] ? '0 : ym_c[COORD_W-1:0];
		end
	end

	// Output stage: far edges kept inside the image; zeros if not done.
	assign xsum_c = {2'b00, x1_s4} + {1'b0, sq_s4};
	assign ysum_c = {2'b00, y1_s4} + {1'b0, sq_s4};
	always_comb begin
		lx_c = x1_s4;
		ty_c = y1_s4;
		rx_c = COORD_W'(xsum_c - LEN_W'(1));
		by_c = COORD_W'(ysum_c - LEN_W'(1));
		if (xsum_c > {1'b0, cfg.width_side}) begin
			rx_c = COORD_W'(cfg.width_side - SIDE_W'(1));
			lx_c = COORD_W'(cfg.width_side - sq_s4);
		end
		if (ysum_c > {1'b0, cfg.height_side}) begin
			by_c = COORD_W'(cfg.height_side - SIDE_W'(1));
			ty_c = COORD_W'(cfg.height_side - sq_s4);
		end
		if (!done_s4) begin
			lx_c = '0;
			ty_c = '0;
			rx_c = '0;
			by_c = '0;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_out_q <= v_s4;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			fg_s1   <= q_data.fg;
			done_s1 <= q_data.done;
			img_s1  <= q_data.img;
			x1_s1   <= n_any ? n_min_c : '0;
			x2_s1   <= n_any ? n_max_c : COORD_W'(cfg.width_side - SIDE_W'(1));
			y1_s1   <= n_any ? n_min_r : '0;
			y2_s1   <= n_any ? n_max_r : COORD_W'(cfg.height_side - SIDE_W'(1));

			fg_s2   <= fg_s1;
			done_s2 <= done_s1;
			img_s2  <= img_s1;
			x1_s2   <= x1_s1;
			y1_s2   <= y1_s1;
			rw_s2   <= rw_c;
			rh_s2   <= rh_c;

			fg_s3   <= fg_s2;
			done_s3 <= done_s2;
			img_s3  <= img_s2;
			x1_s3   <= x1_s2;
			y1_s3   <= y1_s2;
			rw_s3   <= rw_s2;
			rh_s3   <= rh_s2;
			sq_s3   <= sq_c;

			fg_s4   <= fg_s3;
			done_s4 <= done_s3;
			img_s4  <= img_s3;
			x1_s4   <= x1c_c;
			y1_s4   <= y1c_c;
			sq_s4   <= sq_s3;

			fg_q    <= fg_s4;
			done_q  <= done_s4;
			img_q   <= img_s4;
			lx_q    <= lx_c;
			ty_q    <= ty_c;
			rx_q    <= rx_c;
			by_q    <= by_c;
		end
	end

endmodule
